>>> hdl/kvag_pkg.sv
// ----------------------------------------------------------------------------
// kvag_pkg
// Shared types and constants for the KV cache access guard.
// ----------------------------------------------------------------------------
package kvag_pkg;

    localparam int DEF_MAX_LAYERS = 256;

    // field widths
    localparam int CMD_W   = 2;
    localparam int LAYER_W = 10;
    localparam int POS_W   = 32;
    localparam int GEN_W   = 64;
    localparam int CODE_W  = 3;
    localparam int CNT_W   = 32;
    localparam int LIU_W   = 9;
    localparam int LIM_W   = 11;
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 104;
    localparam int ADDR_W   = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd3;

    // failure codes
    localparam logic [CODE_W-1:0] FAIL_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] FAIL_STALE     = 3'd1;
    localparam logic [CODE_W-1:0] FAIL_LAYER     = 3'd2;
    localparam logic [CODE_W-1:0] FAIL_POS       = 3'd3;
    localparam logic [CODE_W-1:0] FAIL_OVERWRITE = 3'd4;
    localparam logic [CODE_W-1:0] FAIL_UNWRITTEN = 3'd5;
    localparam logic [CODE_W-1:0] FAIL_REGRESS   = 3'd6;
    localparam logic [CODE_W-1:0] FAIL_SAME_GEN  = 3'd7;

    // register indexes (paddr[2])
    localparam logic REG_LAYERS_IN_USE = 1'b0;
    localparam logic REG_MAX_POSITION  = 1'b1;

    // reset values
    localparam logic [LIU_W-1:0] RST_LAYERS_IN_USE = 9'd256;
    localparam logic [POS_W-1:0] RST_MAX_POSITION  = 32'd4096;
    localparam logic [GEN_W-1:0] RST_GENERATION    = 64'd1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } tbl_ctl_t;

endpackage

>>> hdl/kvag_table.sv
// ----------------------------------------------------------------------------
// kvag_table
// Per-layer write-end table: synchronous RAM plus a valid bit per entry.
// ----------------------------------------------------------------------------
module kvag_table #(
    parameter int MAX_LAYERS = kvag_pkg::DEF_MAX_LAYERS,
    parameter int IDX_W      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kvag_pkg::tbl_ctl_t      ctl,
    input  logic [IDX_W-1:0]        rd_idx,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic [kvag_pkg::POS_W-1:0] wr_data,
    output logic [kvag_pkg::POS_W-1:0] rd_end
);
    import kvag_pkg::*;

    logic [POS_W-1:0]      mem [MAX_LAYERS];
    logic [MAX_LAYERS-1:0] vld_reg;
    logic [POS_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // entries never written since the last clear read as zero
    assign rd_end = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hdl/kv_cache_access_guard_core.sv
// ----------------------------------------------------------------------------
// kv_cache_access_guard_core
// Checks append/read/advance/reset commands against a per-layer write table.
// ----------------------------------------------------------------------------
// Each command transfer produces exactly one result transfer. The accept
// edge reads the layer's write-end entry into the table RAM's read register;
// once the output register is free, the held command is checked, a successful
// append writes the entry back and the output register is loaded. No second
// command is taken until the held one retires, but a new command is taken
// while a result still waits in the output register; a successful reset
// clears the whole table at once through per-entry valid bits.
module kv_cache_access_guard_core #(
    parameter int MAX_LAYERS = kvag_pkg::DEF_MAX_LAYERS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [9:0] layer, [41:10] position, [105:42] generation, [111:106] zero
    input  logic [kvag_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [kvag_pkg::CMD_W-1:0]     s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] ok, [3:1] fail_code, [6:4] sticky_fail, [38:7] append_total,
    // [70:39] read_total, [102:71] reset_total, [103] zero
    output logic [kvag_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvag_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import kvag_pkg::*;

    localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_LAYERS);

    // configuration
    logic [LIU_W-1:0] layers_in_use_reg;
    logic [POS_W-1:0] max_position_reg;
    logic             cfg_wr;

    // held command
    logic               busy_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [GEN_W-1:0]   gen_reg;

    // architectural state
    logic [POS_W-1:0]  cur_pos_reg,  cur_pos_next;
    logic [GEN_W-1:0]  cur_gen_reg,  cur_gen_next;
    logic [CODE_W-1:0] sticky_reg,   sticky_next;
    logic [CNT_W-1:0]  app_cnt_reg,  app_cnt_next;
    logic [CNT_W-1:0]  rd_cnt_reg,   rd_cnt_next;
    logic [CNT_W-1:0]  rst_cnt_reg,  rst_cnt_next;

    // output register
    logic                m_valid_reg;
    logic                ok_reg;
    logic [CODE_W-1:0]   code_reg;

    logic               accept;
    logic               fin;
    logic [CODE_W-1:0]  code;
    logic [POS_W-1:0]   wr_end;
    logic [POS_W-1:0]   tbl_end;
    logic [LIM_W-1:0]   lim;
    logic               layer_ok;
    logic               gen_match;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   cur_inc;
    tbl_ctl_t           tbl_ctl;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layers_in_use_reg <= RST_LAYERS_IN_USE;
            max_position_reg  <= RST_MAX_POSITION;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                REG_LAYERS_IN_USE: layers_in_use_reg <= pwdata[LIU_W-1:0];
                REG_MAX_POSITION:  max_position_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LAYERS_IN_USE: prdata = {{(32-LIU_W){1'b0}}, layers_in_use_reg};
            REG_MAX_POSITION:  prdata = max_position_reg;
            default:           prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    // the checked command retires once the output register is free
    assign fin      = busy_reg && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end
            if (fin)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            layer_reg <= s_tdata[LAYER_W-1:0];
            pos_reg   <= s_tdata[LAYER_W+POS_W-1:LAYER_W];
            gen_reg   <= s_tdata[LAYER_W+POS_W+GEN_W-1:LAYER_W+POS_W];
        end
    end

    // ---------------- table ----------------
    kvag_table #(
        .MAX_LAYERS (MAX_LAYERS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_idx  (s_tdata[IDX_W-1:0]),
        .wr_idx  (layer_reg[IDX_W-1:0]),
        .wr_data (wr_end),
        .rd_end  (tbl_end)
    );

    // ---------------- check ----------------
    assign lim       = ({2'b00, layers_in_use_reg} > LIM_MAX) ? LIM_MAX
                                                              : {2'b00, layers_in_use_reg};
    assign layer_ok  = {1'b0, layer_reg} < lim;
    assign gen_match = gen_reg == cur_gen_reg;
    assign pos_inc   = pos_reg + 32'd1;
    assign cur_inc   = cur_pos_reg + 32'd1;
    assign wr_end    = pos_inc;

    always_comb
    begin
        code = FAIL_NONE;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (!gen_match)
                    code = FAIL_STALE;
                else if (!layer_ok)
                    code = FAIL_LAYER;
                else if (pos_reg >= max_position_reg)
                    code = FAIL_POS;
                else if (pos_reg != tbl_end && pos_reg != cur_pos_reg && pos_reg < tbl_end)
                    code = FAIL_OVERWRITE;
            end
            CMD_READ:
            begin
                if (!gen_match)
                    code = FAIL_STALE;
                else if (!layer_ok || pos_reg >= tbl_end)
                    code = FAIL_UNWRITTEN;
            end
            CMD_ADVANCE:
            begin
                if (pos_reg != cur_inc && pos_reg < cur_pos_reg)
                    code = FAIL_REGRESS;
            end
            CMD_RESET:
            begin
                if (gen_match)
                    code = FAIL_SAME_GEN;
            end
            default: code = FAIL_NONE;
        endcase
    end

    always_comb
    begin
        cur_pos_next = cur_pos_reg;
        cur_gen_next = cur_gen_reg;
        sticky_next  = sticky_reg;
        app_cnt_next = app_cnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        rst_cnt_next = rst_cnt_reg;
        tbl_ctl.rd_en = accept;
        tbl_ctl.wr_en = 1'b0;
        tbl_ctl.clr   = 1'b0;
        if (code != FAIL_NONE)
        begin
            sticky_next = code;
        end
        else
        begin
            case (cmd_reg)
                CMD_APPEND:
                begin
                    tbl_ctl.wr_en = fin;
                    app_cnt_next  = app_cnt_reg + 32'd1;
                end
                CMD_READ:
                begin
                    rd_cnt_next = rd_cnt_reg + 32'd1;
                end
                CMD_ADVANCE:
                begin
                    cur_pos_next = pos_reg;
                end
                CMD_RESET:
                begin
                    tbl_ctl.clr  = fin;
                    cur_pos_next = '0;
                    cur_gen_next = gen_reg;
                    sticky_next  = FAIL_NONE;
                    rst_cnt_next = rst_cnt_reg + 32'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            cur_gen_reg <= RST_GENERATION;
            sticky_reg  <= FAIL_NONE;
            app_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            rst_cnt_reg <= '0;
        end
        else if (fin)
        begin
            cur_pos_reg <= cur_pos_next;
            cur_gen_reg <= cur_gen_next;
            sticky_reg  <= sticky_next;
            app_cnt_reg <= app_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            rst_cnt_reg <= rst_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            ok_reg   <= code == FAIL_NONE;
            code_reg <= code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, rst_cnt_reg, rd_cnt_reg, app_cnt_reg,
                       sticky_reg, code_reg, ok_reg};

`ifndef SYNTHESIS
    // a stalled result holds the checked command in place
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && m_valid_reg && !m_tready |=> busy_reg)
        else $error("command dropped while output stalled");

    // a retired command always lands in the output register
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> m_valid_reg && ok_reg == (code_reg == FAIL_NONE))
        else $error("result not loaded or ok/fail_code mismatch");

    // a successful reset leaves the sticky code clear
    a_reset_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fin && cmd_reg == CMD_RESET && code == FAIL_NONE |=> sticky_reg == FAIL_NONE)
        else $error("sticky failure survived a reset");
`endif

endmodule
